// File: rtl/core/fixed_block_pool_allocator_assert.svh
// Assertion macros used by the checker module of the block pool allocator.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa: next-cycle check failed");

`endif

// File: rtl/core/fbpa_pkg.sv
// Shared types, constants and helper functions for the block pool allocator.
// Used by every module of the block but fbpa_ram; depends on nothing.
package fbpa_pkg;

    localparam int MaxBlocks  = 256;
    localparam int IndexW     = $clog2(MaxBlocks);
    localparam int CountW     = IndexW + 1;
    localparam int AlignBytes = 8;
    localparam int AlignShift = $clog2(AlignBytes);
    localparam int BytesW     = 13;
    localparam int StrideW    = BytesW + 1 - AlignShift;
    localparam int AddrW      = 20;
    localparam int CfgW       = BytesW;
    localparam int CfgIdxW    = 1;

    localparam logic [CountW-1:0] LIST_EMPTY        = CountW'(MaxBlocks);
    localparam logic [CountW-1:0] BLOCK_COUNT_RESET = CountW'(MaxBlocks);
    localparam logic [BytesW-1:0] BLOCK_BYTES_RESET = BytesW'(16);

    localparam logic [CfgIdxW-1:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_BLOCK_BYTES = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef enum logic [0:0] {
        FSM_IDLE,
        FSM_LINK_RD
    } fsm_t;

    typedef struct packed {
        logic              action;
        logic [IndexW-1:0] block_index;
    } req_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [IndexW-1:0] given_index;
        logic [AddrW-1:0]  given_address;
        logic [CountW-1:0] free_blocks;
    } rsp_word_t;

    typedef struct packed {
        logic               restart;
        logic [CountW-1:0]  restart_total;
        logic [CountW-1:0]  count;
        logic [StrideW-1:0] stride_units;
    } pool_cfg_t;

    // Counts above the pool size saturate to the pool size.
    function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] raw);
        logic [CountW-1:0] result;
        result = (raw > LIST_EMPTY) ? LIST_EMPTY : raw;
        return result;
    endfunction

endpackage

// File: rtl/core/fbpa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Self-contained; no package is used.
module fbpa_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fbpa_ctrl.sv
// Free-list controller: pool state registers, decision logic and result register.
// Depends on fbpa_pkg; drives the link memory held in the top level.
module fbpa_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fbpa_pkg::pool_cfg_t               cfg,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  fbpa_pkg::req_word_t               req_word,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output fbpa_pkg::rsp_word_t               rsp_word,
    output logic                              link_we,
    output logic [fbpa_pkg::IndexW-1:0]       link_waddr,
    output logic [fbpa_pkg::IndexW-1:0]       link_wdata,
    output logic [fbpa_pkg::IndexW-1:0]       link_raddr,
    input  logic [fbpa_pkg::IndexW-1:0]       link_rdata
);

    localparam int ProdW = fbpa_pkg::IndexW + fbpa_pkg::StrideW;

    fbpa_pkg::fsm_t              state_reg, state_next;
    logic [fbpa_pkg::CountW-1:0] head_reg, head_next;
    logic [fbpa_pkg::CountW-1:0] bump_reg, bump_next;
    logic [fbpa_pkg::CountW-1:0] total_reg, total_next;
    logic                        rsp_valid_reg;
    fbpa_pkg::rsp_word_t         rsp_word_reg, rsp_word_next;

    logic                        req_fire;
    logic                        head_load_link;
    logic [fbpa_pkg::CountW-1:0] list_len;
    logic                        list_ok;
    logic                        pop_link;
    logic                        push_ok;
    logic [1:0]                  status;
    logic [fbpa_pkg::IndexW-1:0] idx;
    logic [ProdW-1:0]            product;

    assign req_fire = req_valid && req_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (cfg.restart)
        begin
            state_next = fbpa_pkg::FSM_IDLE;
        end
        else
        begin
            unique case (state_reg)
                fbpa_pkg::FSM_IDLE:
                begin
                    if (req_fire && pop_link)
                    begin
                        state_next = fbpa_pkg::FSM_LINK_RD;
                    end
                end
                fbpa_pkg::FSM_LINK_RD:
                begin
                    state_next = fbpa_pkg::FSM_IDLE;
                end
                default:
                begin
                    state_next = fbpa_pkg::FSM_IDLE;
                end
            endcase
        end
    end

    // State machine outputs.
    always_comb
    begin
        req_ready      = 1'b0;
        head_load_link = 1'b0;
        unique case (state_reg)
            fbpa_pkg::FSM_IDLE:
            begin
                req_ready = !rsp_valid_reg || rsp_ready;
            end
            fbpa_pkg::FSM_LINK_RD:
            begin
                head_load_link = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Decision for the word on the input, applied only when it is accepted.
    always_comb
    begin
        list_len  = total_reg - cfg.count + bump_reg;
        list_ok   = !head_reg[fbpa_pkg::IndexW] && (list_len != '0);
        head_next  = head_reg;
        bump_next  = bump_reg;
        total_next = total_reg;
        status     = fbpa_pkg::STATUS_OK;
        idx        = '0;
        pop_link   = 1'b0;
        push_ok    = 1'b0;
        if (req_word.action == fbpa_pkg::ACT_ALLOC)
        begin
            priority if (list_ok)
            begin
                idx        = head_reg[fbpa_pkg::IndexW-1:0];
                total_next = total_reg - 1'b1;
                if (list_len != fbpa_pkg::CountW'(1))
                begin
                    pop_link = 1'b1;
                end
                else
                begin
                    head_next = fbpa_pkg::LIST_EMPTY;
                end
            end
            else if (bump_reg < cfg.count)
            begin
                idx        = bump_reg[fbpa_pkg::IndexW-1:0];
                bump_next  = bump_reg + 1'b1;
                total_next = total_reg - 1'b1;
            end
            else
            begin
                status = fbpa_pkg::STATUS_EMPTY;
            end
        end
        else
        begin
            if (({1'b0, req_word.block_index} >= cfg.count) || (total_reg >= cfg.count))
            begin
                status = fbpa_pkg::STATUS_BAD_FREE;
            end
            else
            begin
                push_ok    = 1'b1;
                idx        = req_word.block_index;
                head_next  = {1'b0, req_word.block_index};
                total_next = total_reg + 1'b1;
            end
        end

        product = ProdW'(idx) * ProdW'(cfg.stride_units);
        rsp_word_next.status        = status;
        rsp_word_next.given_index   = idx;
        rsp_word_next.given_address =
            fbpa_pkg::AddrW'({product, {fbpa_pkg::AlignShift{1'b0}}});
        rsp_word_next.free_blocks   = total_next;
    end

    // The pushed block links to the old head, or to nothing on an empty list.
    assign link_we    = req_fire && push_ok;
    assign link_waddr = req_word.block_index;
    assign link_wdata = (list_len != '0) ? head_reg[fbpa_pkg::IndexW-1:0] : '0;
    assign link_raddr = head_reg[fbpa_pkg::IndexW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbpa_pkg::FSM_IDLE;
            head_reg      <= fbpa_pkg::LIST_EMPTY;
            bump_reg      <= '0;
            total_reg     <= fbpa_pkg::BLOCK_COUNT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            priority if (cfg.restart)
            begin
                head_reg  <= fbpa_pkg::LIST_EMPTY;
                bump_reg  <= '0;
                total_reg <= cfg.restart_total;
            end
            else if (head_load_link)
            begin
                head_reg <= {1'b0, link_rdata};
            end
            else if (req_fire)
            begin
                head_reg  <= head_next;
                bump_reg  <= bump_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// File: rtl/core/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator: configuration registers,
// the free-list controller and the link memory. Depends on fbpa_pkg, fbpa_ctrl, fbpa_ram.

// The allocator hands out and takes back blocks of one size from a pool of up to
// 256 blocks. Each request word either allocates a block (most recently freed
// block first, otherwise the next block never yet used) or frees one; each
// produces exactly one response word with the status, the block index, its byte
// offset (index times the block size rounded up to 8 bytes, kept to 20 bits) and
// the number of free blocks left. Frees of an index outside the pool, or made
// while every block is already free, are reported and change nothing; freeing a
// block twice is not detected. An allocation that pops the free list while more
// than one freed block remains holds off the next request while the new list head
// is read from the link memory, whose read data are registered. The response sits
// in an output register, and a new request is taken in the same cycle as the
// waiting response is taken. Writing either configuration register restarts the
// pool at once: the free list is emptied, every block counts as unused and the
// free count equals the block count (counts above 256 are held at 256). The link
// memory needs no clearing after reset.
module fixed_block_pool_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  fbpa_pkg::req_word_t            req_word,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output fbpa_pkg::rsp_word_t            rsp_word,
    input  logic                           cfg_write_en,
    input  logic [fbpa_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [fbpa_pkg::CfgW-1:0]      cfg_data
);

    logic [fbpa_pkg::CountW-1:0]   count_reg;
    logic [fbpa_pkg::BytesW-1:0]   bytes_reg;
    logic [fbpa_pkg::CountW-1:0]   count_next;
    logic [fbpa_pkg::BytesW:0]     bytes_round;
    fbpa_pkg::pool_cfg_t           cfg;

    logic                          link_we;
    logic [fbpa_pkg::IndexW-1:0]   link_waddr;
    logic [fbpa_pkg::IndexW-1:0]   link_wdata;
    logic [fbpa_pkg::IndexW-1:0]   link_raddr;
    logic [fbpa_pkg::IndexW-1:0]   link_rdata;

    // The count the pool will have after this cycle, needed so that a restart
    // loads the free count from the value being written.
    assign count_next = (cfg_write_en && (cfg_index == fbpa_pkg::CFG_BLOCK_COUNT))
                        ? cfg_data[fbpa_pkg::CountW-1:0] : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= fbpa_pkg::BLOCK_COUNT_RESET;
            bytes_reg <= fbpa_pkg::BLOCK_BYTES_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_BLOCK_COUNT:
                begin
                    count_reg <= cfg_data[fbpa_pkg::CountW-1:0];
                end
                fbpa_pkg::CFG_BLOCK_BYTES:
                begin
                    bytes_reg <= cfg_data[fbpa_pkg::BytesW-1:0];
                end
                default:
                begin
                    bytes_reg <= bytes_reg;
                end
            endcase
        end
    end

    // The stride is kept in units of the alignment, so the address multiply
    // stays narrow and the low address bits are simply zero.
    assign bytes_round = {1'b0, bytes_reg} + (fbpa_pkg::BytesW + 1)'(fbpa_pkg::AlignBytes - 1);

    always_comb
    begin
        cfg.restart       = cfg_write_en;
        cfg.restart_total = fbpa_pkg::eff_count(count_next);
        cfg.count         = fbpa_pkg::eff_count(count_reg);
        cfg.stride_units  = bytes_round[fbpa_pkg::BytesW:fbpa_pkg::AlignShift];
    end

    fbpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_word   (req_word),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_word   (rsp_word),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata)
    );

    // One link per block: the index of the block freed before it.
    fbpa_ram #(
        .Width (fbpa_pkg::IndexW),
        .Depth (fbpa_pkg::MaxBlocks)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

endmodule

// File: rtl/core/fbpa_checker.sv
// Port-level checker for the block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_assert.svh.
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  fbpa_pkg::rsp_word_t            rsp_word
);

    logic rsp_failed;
    logic rsp_no_block;
    logic rsp_empty;
    logic rsp_none_free;
    logic req_fire;
    logic rsp_stalled;

    assign rsp_failed    = rsp_valid && (rsp_word.status != fbpa_pkg::STATUS_OK);
    assign rsp_no_block  = (rsp_word.given_index == '0) && (rsp_word.given_address == '0);
    assign rsp_empty     = rsp_valid && (rsp_word.status == fbpa_pkg::STATUS_EMPTY);
    assign rsp_none_free = (rsp_word.free_blocks == '0);
    assign req_fire      = req_valid && req_ready;
    assign rsp_stalled   = rsp_valid && !rsp_ready;

    // A failed request reports neither a block nor an address.
    `FBPA_ASSERT_NOW(a_fail_zero, clk, rst_n, rsp_failed, rsp_no_block)

    // An empty pool on allocation can only mean no free block at all.
    `FBPA_ASSERT_NOW(a_empty_none_free, clk, rst_n, rsp_empty, rsp_none_free)

    // Every accepted request has its response waiting in the next cycle.
    `FBPA_ASSERT_NEXT(a_req_gives_rsp, clk, rst_n, req_fire, rsp_valid)

    // A response that is not taken stays as it is.
    `FBPA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stalled, rsp_valid && $stable(rsp_word))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
